[sv/bhpq_pkg.sv]
package bhpq_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 1;
   localparam int VALUE_W  = 32;
   localparam int ENTRY_W  = 11;
   localparam int RSP_W    = 48;
   localparam int RSP_PAD  = RSP_W - VALUE_W - 2 - ENTRY_W;

   localparam logic [CNT_W-1:0]   FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [VALUE_W-1:0] EMPTY_ROOT = '1;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_UP,
      ST_INS_CMP,
      ST_REM_ROOT,
      ST_REM_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DONE
   } state_type;

   // True when a strictly beats b; order 0 puts larger values first.
   function automatic logic beats(input logic [VALUE_W-1:0] a,
                                  input logic [VALUE_W-1:0] b,
                                  input logic order);
      logic lt;
      logic gt;
      lt = $signed(a) < $signed(b);
      gt = $signed(a) > $signed(b);
      return order ? lt : gt;
   endfunction

endpackage

[sv/binary_heap_priority_queue.sv]
// Binary heap priority queue of signed 32-bit values.
// Requests arrive on the req_ channel: req_tuser selects insert (0) or
// remove-root (1), req_tdata carries the value to insert. Every request
// yields exactly one response on the rsp_ channel carrying the removed root
// (-1 from an empty heap, 0 on insert), the empty and overflow flags and
// the number of entries held afterwards. An insert into a full heap is
// dropped and flagged.
// One request is processed at a time in a store with one write port and
// a registered read port; req_tready is high only while the sequencer is
// idle. An insert reads and compares the parent for each level it moves
// (at most 10 for 1024 entries); a remove reads the root and the last
// entry, then for each level reads both children and compares. A waiting
// response does not stop the sequencer from finishing, but a new request
// is only taken once its predecessor's response has entered the response
// register. The user must write the order select bit through csr_wr_en
// and csr_wr_data only while the block is idle, which it does not enforce.
// Reset empties the heap, selects max-first order and clears the response
// valid flag; the store itself needs no clearing.
module binary_heap_priority_queue
   import bhpq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // value
   input  logic [0:0]         req_tuser,   // action
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // root_value, was_empty, overflow, entry_count
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   logic [VALUE_W-1:0] heap_mem [CAPACITY];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [VALUE_W-1:0] left_val_ff, left_val_in;
   logic [VALUE_W-1:0] root_ff, root_in;
   logic               empty_ff, empty_in;
   logic               ovf_ff, ovf_in;
   logic               order_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [VALUE_W-1:0] mem_wd;
   logic [ADDR_W-1:0]  mem_ra;

   logic [ADDR_W-1:0]  parent;
   logic [CHILD_W-1:0] left_idx;
   logic [CHILD_W-1:0] right_idx;
   logic [CHILD_W-1:0] count_ext;
   logic               right_ok;
   logic               take_right;
   logic [VALUE_W-1:0] pick_val;
   logic [ADDR_W-1:0]  pick_idx;
   logic               rsp_free;

   assign parent     = (pos_ff - ADDR_W'(1)) >> 1;
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = left_idx + CHILD_W'(1);
   assign count_ext  = CHILD_W'(count_ff);
   assign right_ok   = right_idx < count_ext;
   assign take_right = right_ok && beats(rd_data_ff, left_val_ff, order_ff);
   assign pick_val   = take_right ? rd_data_ff : left_val_ff;
   assign pick_idx   = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= heap_mem[mem_ra];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      left_val_in  = left_val_ff;
      root_in      = root_ff;
      empty_in     = empty_ff;
      ovf_in       = ovf_ff;
      mem_we       = 1'b0;
      mem_wa       = pos_ff;
      mem_wd       = val_ff;
      mem_ra       = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               root_in  = '0;
               empty_in = 1'b0;
               ovf_in   = 1'b0;
               if (req_tuser[0] == ACT_INSERT) begin
                  if (count_ff >= FULL_COUNT) begin
                     ovf_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = count_ff[ADDR_W-1:0];
                     val_in   = req_tdata;
                     state_in = ST_INS_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     root_in  = EMPTY_ROOT;
                     empty_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_REM_ROOT;
                  end
               end
            end
         end
         ST_INS_UP: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               mem_ra   = parent;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            mem_we = 1'b1;
            if (beats(val_ff, rd_data_ff, order_ff)) begin
               mem_wd   = rd_data_ff;
               pos_in   = parent;
               state_in = ST_INS_UP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_REM_ROOT: begin
            root_in = rd_data_ff;
            mem_ra  = count_ff[ADDR_W-1:0];
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_REM_LAST;
            end
         end
         ST_REM_LAST: begin
            val_in   = rd_data_ff;
            pos_in   = '0;
            state_in = ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            if (left_idx >= count_ext) begin
               mem_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               mem_ra   = left_idx[ADDR_W-1:0];
               state_in = ST_DN_RIGHT;
            end
         end
         ST_DN_RIGHT: begin
            left_val_in = rd_data_ff;
            mem_ra      = right_idx[ADDR_W-1:0];
            state_in    = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (beats(pick_val, val_ff, order_ff)) begin
               mem_wd   = pick_val;
               pos_in   = pick_idx;
               state_in = ST_DN_LEFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {RSP_PAD'(0), ENTRY_W'(count_ff), ovf_ff, empty_ff, root_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      left_val_ff <= left_val_in;
      root_ff     <= root_in;
      empty_ff    <= empty_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("heap count exceeds capacity");

   a_store_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != ST_IDLE && state_ff != ST_DONE)
      else $error("store written outside a sift");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[VALUE_W] |->
         rsp_tdata[VALUE_W-1:0] == EMPTY_ROOT && rsp_tdata[VALUE_W+2+:ENTRY_W] == '0)
      else $error("empty response carries a root or a count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[VALUE_W+1] |->
         rsp_tdata[VALUE_W+2+:ENTRY_W] == ENTRY_W'(CAPACITY))
      else $error("overflow flagged below capacity");

endmodule
